[rtl/wvm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_pkg - shared types and constants for the wind vector mean block
// Angle table, CORDIC gain and the word passed from front to back.
// ----------------------------------------------------------------------------
package wvm_pkg;

  localparam int TabLen = 24;
  localparam logic [29:0] GainQ30 = 30'd652032874;
  localparam logic [35:0] Half180 = 36'd1179648000;  // 18000 * 65536

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] direction;
    logic        restart;
  } sample_t;

  function automatic logic [35:0] atan_entry(input logic [4:0] idx);
    logic [35:0] r;
    case (idx)
      5'd0: r = 36'd294912000;
      5'd1: r = 36'd174096719;
      5'd2: r = 36'd91987925;
      5'd3: r = 36'd46694507;
      5'd4: r = 36'd23437865;
      5'd5: r = 36'd11730358;
      5'd6: r = 36'd5866610;
      5'd7: r = 36'd2933484;
      5'd8: r = 36'd1466765;
      5'd9: r = 36'd733385;
      5'd10: r = 36'd366693;
      5'd11: r = 36'd183346;
      5'd12: r = 36'd91673;
      5'd13: r = 36'd45837;
      5'd14: r = 36'd22918;
      5'd15: r = 36'd11459;
      5'd16: r = 36'd5730;
      5'd17: r = 36'd2865;
      5'd18: r = 36'd1432;
      5'd19: r = 36'd716;
      5'd20: r = 36'd358;
      5'd21: r = 36'd179;
      5'd22: r = 36'd90;
      5'd23: r = 36'd45;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/wvm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_queue - input front and two-entry queue
// Accepts sample words and holds them until the back end takes one.
// ----------------------------------------------------------------------------
module wvm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wvm_pkg::sample_t in_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wvm_pkg::sample_t      out_word
);

  wvm_pkg::sample_t slot [2];
  logic             rd_ptr;
  logic             wr_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_word  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_word;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule
`default_nettype wire

[rtl/wvm_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_core - back end: CORDIC rotation, accumulate, vectoring, mean
// One shared CORDIC datapath iterated per step, then a serial divider.
// ----------------------------------------------------------------------------
module wvm_core #(
  parameter int MAX_SAMPLES  = 255,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wvm_pkg::sample_t in_word,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic [15:0]           avg_speed,
  output logic [15:0]           avg_direction,
  output logic [7:0]            samples_taken,
  output logic                  count_full
);

  localparam int Steps = (CORDIC_STEPS > wvm_pkg::TabLen) ? wvm_pkg::TabLen : CORDIC_STEPS;
  localparam logic [4:0] LastStep = 5'(Steps - 1);
  localparam logic [7:0] MaxTally = 8'(MAX_SAMPLES);
  localparam int DW = 12;  // divisor 16n fits in 12 bits
  localparam int NW = 44;  // numerator width

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_ROT, S_ACC, S_VSET, S_VEC, S_MAG,
    S_DIVSET, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t         state;
  logic signed [47:0] x, y;
  logic signed [39:0] z;
  logic [4:0]     step;
  logic           flip;
  logic signed [25:0] sum_east, sum_north;
  logic [7:0]     sample_tally;
  logic [15:0]    spd_in;
  logic [NW-1:0]  num;
  logic [NW-1:0]  rem;
  logic [5:0]     bitc;
  logic [NW-1:0]  quo;
  logic [DW-1:0]  dvs;
  logic signed [16:0] dsig;

  logic signed [47:0] dx, dy;
  logic signed [39:0] at;
  logic signed [25:0] uc, vc;
  logic [NW:0]    trial;
  logic signed [23:0] zr;
  logic signed [24:0] dirv;
  logic [15:0]    dfold;
  logic [61:0]    mprod;

  function automatic logic signed [25:0] comp_sat(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = (v + 48'sd8192) >>> 14;
    if (r > 48'sd65535) return 26'sd65535;
    if (r < -48'sd65535) return -26'sd65535;
    return r[25:0];
  endfunction

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = $signed({4'd0, wvm_pkg::atan_entry(step)});
  assign uc = comp_sat(y);
  assign vc = comp_sat(x);
  assign trial = {rem[NW-1:0], num[NW-1]} - {{(NW+1-DW){1'b0}}, dvs};
  assign zr = 24'((z + 40'sd32768) >>> 16);
  assign dirv = 25'sd27000 - 25'(zr);
  // vectored magnitude stays below 2^31, so the low 32 bits of x suffice
  assign mprod = 62'(x[31:0]) * 62'(wvm_pkg::GainQ30);

  always_comb begin
    logic signed [24:0] t;
    t = dirv;
    // fold into 0..35999; angle stays within a few turns
    if (t < 0) t = t + 25'sd36000;
    if (t < 0) t = t + 25'sd36000;
    if (t >= 25'sd36000) t = t - 25'sd36000;
    if (t >= 25'sd36000) t = t - 25'sd36000;
    dfold = t[15:0];
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      sum_east     <= '0;
      sum_north    <= '0;
      sample_tally <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            spd_in <= in_word.speed;
            dsig   <= {1'b0, in_word.direction};
            if (in_word.restart) begin
              sum_east     <= '0;
              sum_north    <= '0;
              sample_tally <= '0;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // reduce modulo 36000 by compare-subtract, then fold to +-9000
          logic signed [16:0] d;
          logic               f;
          d = dsig;
          f = 1'b0;
          if (d >= 17'sd36000) d = d - 17'sd36000;
          if (d >= 17'sd18000) d = d - 17'sd36000;
          if (d > 17'sd9000) begin
            d = d - 17'sd18000;
            f = 1'b1;
          end else if (d < -17'sd9000) begin
            d = d + 17'sd18000;
            f = 1'b1;
          end
          flip <= f;
          z <= 40'(d) <<< 16;
          if (sample_tally < MaxTally) state <= S_MUL;
          else state <= S_VSET;
        end
        S_MUL: begin
          x    <= $signed({16'd0, 32'((48'(spd_in) * 48'(wvm_pkg::GainQ30)) >> 16)});
          y    <= '0;
          step <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (z >= 0) begin
            x <= x - dx; y <= y + dy; z <= z - at;
          end else begin
            x <= x + dx; y <= y - dy; z <= z + at;
          end
          if (step == LastStep) state <= S_ACC;
          step <= step + 5'd1;
        end
        S_ACC: begin
          if (flip) begin
            sum_east  <= sum_east + uc;
            sum_north <= sum_north + vc;
          end else begin
            sum_east  <= sum_east + comp_sat(-y);
            sum_north <= sum_north + comp_sat(-x);
          end
          sample_tally <= sample_tally + 8'd1;
          state <= S_VSET;
        end
        S_VSET: begin
          step <= '0;
          if (sum_east < 0) begin
            x <= -(48'(sum_east) <<< 4);
            y <= -(48'(sum_north) <<< 4);
            z <= $signed({4'd0, wvm_pkg::Half180});
          end else begin
            x <= 48'(sum_east) <<< 4;
            y <= 48'(sum_north) <<< 4;
            z <= '0;
          end
          state <= S_VEC;
        end
        S_VEC: begin
          if (y > 0) begin
            x <= x + dx; y <= y - dy; z <= z + at;
          end else begin
            x <= x - dx; y <= y + dy; z <= z - at;
          end
          if (step == LastStep) state <= S_MAG;
          step <= step + 5'd1;
        end
        S_MAG: begin
          if (x < 0) x <= '0;
          state <= S_DIVSET;
        end
        S_DIVSET: begin
          logic [11:0] n;
          n = (sample_tally == 8'd0) ? 12'd1 : {4'd0, sample_tally};
          num  <= NW'(mprod >> 30) + NW'({n, 3'd0});
          dvs  <= DW'({n, 4'd0});
          rem  <= '0;
          quo  <= '0;
          bitc <= 6'(NW);
          state <= S_DIV;
        end
        S_DIV: begin
          if (!trial[NW]) begin
            rem <= trial[NW-1:0];
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= {rem[NW-2:0], num[NW-1]};
            quo <= {quo[NW-2:0], 1'b0};
          end
          num  <= {num[NW-2:0], 1'b0};
          bitc <= bitc - 6'd1;
          if (bitc == 6'd1) state <= S_FIN;
        end
        S_FIN: begin
          logic [15:0] s;
          s = (quo > NW'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
          avg_speed     <= s;
          avg_direction <= (s == 16'd0) ? 16'd0 : dfold;
          samples_taken <= sample_tally;
          count_full    <= (sample_tally >= MaxTally);
          res_valid     <= 1'b1;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/wind_vector_mean.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wind_vector_mean - running vector mean of wind samples
// Polar sample in, mean speed and direction of all samples since restart out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample word: speed, direction and a restart flag in
//   tuser. Each accepted word yields exactly one m_axis word with the mean
//   speed, the mean direction, the sample count and a saturation flag.
//   From s_axis accept to m_axis_tvalid a word passes the queue, one
//   rotation pass of the shared CORDIC unit, one vectoring pass, then a
//   44-bit restoring divider that yields one quotient bit a cycle. A word
//   that finds the count full skips the rotation. The back end works on
//   one word at a time.
//   A two-word queue in front lets the source hand over words while the
//   back end is busy or the sink stalls. A stalled result holds m_axis
//   stable; the back end waits until it is taken.
//   Reset (rst, synchronous) clears sums, count, queue and m_axis_tvalid.
//   Once the count reaches MAX_SAMPLES further samples leave the sums
//   unchanged and count_full is 1, until a restart word arrives.
// ----------------------------------------------------------------------------
module wind_vector_mean #(
  parameter int MAX_SAMPLES  = 255,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] speed_in, [31:16] direction_in
  input  wire logic        s_axis_tuser,   // restart
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [15:0] avg_speed, [31:16] avg_direction,
                                           // [39:32] samples_taken
  output logic             m_axis_tuser    // count_full
);

  wvm_pkg::sample_t in_word;
  wvm_pkg::sample_t q_word;
  logic             q_valid;
  logic             q_ready;
  logic [15:0]      avg_speed;
  logic [15:0]      avg_direction;
  logic [7:0]       samples_taken;

  assign in_word.speed     = s_axis_tdata[15:0];
  assign in_word.direction = s_axis_tdata[31:16];
  assign in_word.restart   = s_axis_tuser;

  wvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_word   (in_word),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_word  (q_word)
  );

  wvm_core #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .in_word       (q_word),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .avg_speed     (avg_speed),
    .avg_direction (avg_direction),
    .samples_taken (samples_taken),
    .count_full    (m_axis_tuser)
  );

  assign m_axis_tdata = {samples_taken, avg_direction, avg_speed};

endmodule
`default_nettype wire

[rtl/wvm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvm_checker - port-level checks for wind_vector_mean
// Output handshake and result field sanity.
// ----------------------------------------------------------------------------
module wvm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_dir: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:16] < 16'd36000)
    else $error("direction out of range");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[15:0] == 16'd0 |-> m_axis_tdata[31:16] == 16'd0)
    else $error("zero speed with nonzero direction");

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:32] != 8'd0)
    else $error("zero sample count");

endmodule

bind wind_vector_mean wvm_checker u_wvm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
